// ===== src/binary_to_intel_hex_encoder_unit_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef BINARY_TO_INTEL_HEX_ENCODER_UNIT_MACROS_SVH
`define BINARY_TO_INTEL_HEX_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define BTIH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define BTIH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/btih_pkg.sv =====
`timescale 1ns / 1ps

package btih_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [6:0] t_char;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic CFG_LOAD_ADDR = 1'b0;
    localparam logic CFG_END_ADDR  = 1'b1;

    localparam t_byte TYPE_DATA    = 8'h00;
    localparam t_byte TYPE_END     = 8'h01;
    localparam t_byte TYPE_SEGMENT = 8'h04;
    localparam t_byte SEG_LEN      = 8'h02;

    function automatic t_char hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (7'h30 + 7'(nib)) : (7'h37 + 7'(nib));
    endfunction

endpackage

// ===== src/btih_ram.sv =====
`timescale 1ns / 1ps

module btih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/binary_to_intel_hex_encoder_unit.sv =====
`timescale 1ns / 1ps
// Intel HEX record encoder.
// Slave stream: one word per input item; tuser[0] = cmd (0 data byte, 1 end),
// tdata[7:0] = data byte. Master stream: one word per record byte; tdata
// carries the byte and its two ASCII hex digits, tuser the record start/end
// flags, tlast marks the final record byte caused by one input word.
// Config: i_cfg_we with i_cfg_index 0 loads the start address of the current
// row, index 1 sets the end record address field. Write only while idle.
// A data byte that does not complete a row is taken and gives no output. A
// row-completing byte or an end word moves the state out of idle and starts a
// record burst: one record byte per cycle while the receiver is ready, from a
// single sequencer and running checksum adder, ROW_BYTES+5 bytes for a full
// data record, plus 7 for an extended address record and 5 for the end record.
// The slave side is not ready until the burst is handed to the output register.
// A stalled receiver holds the output register and freezes the sequencer.
// Reset clears the row, the address (0), the segment (0) and the output.

`include "binary_to_intel_hex_encoder_unit_macros.svh"

module binary_to_intel_hex_encoder_unit #(
    parameter int ROW_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_tuser,   // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] record_byte, [14:8] hex_high_char,
                                     // [21:15] hex_low_char, [23:22] zero
    output logic [1:0]  o_m_tuser,   // [0] record_start, [1] record_end
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int FILL_W = $clog2(ROW_BYTES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEG  = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;
    localparam logic [1:0] ST_END  = 2'd3;

    localparam logic [2:0] PH_LEN = 3'd0;
    localparam logic [2:0] PH_AH  = 3'd1;
    localparam logic [2:0] PH_AL  = 3'd2;
    localparam logic [2:0] PH_TYP = 3'd3;
    localparam logic [2:0] PH_PAY = 3'd4;
    localparam logic [2:0] PH_SUM = 3'd5;

    logic [1:0]          r_state, n_state;
    logic [2:0]          r_phase, n_phase;
    logic [IDX_W-1:0]    r_idx, n_idx;
    btih_pkg::t_byte     r_len, n_len;
    btih_pkg::t_byte     r_sum, n_sum;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [31:0]         r_cur, n_cur;
    logic [15:0]         r_last_seg, n_last_seg;
    logic [15:0]         r_end_addr, n_end_addr;
    logic                r_end_pend, n_end_pend;
    logic                r_out_valid, n_out_valid;
    logic [23:0]         r_out_data, n_out_data;
    logic [1:0]          r_out_user, n_out_user;
    logic                r_out_last, n_out_last;

    btih_pkg::t_byte     w_rd_data;
    btih_pkg::t_byte     w_byte;
    btih_pkg::t_byte     w_payload;
    logic [15:0]         w_addr;
    btih_pkg::t_byte     w_type;
    logic                w_accept;
    logic                w_step;
    logic [FILL_W-1:0]   w_fill_flush;

    btih_ram #(
        .WIDTH (8),
        .DEPTH (ROW_BYTES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_s_tuser[0] == btih_pkg::CMD_DATA)),
        .i_waddr (r_fill[IDX_W-1:0]),
        .i_wdata (i_s_tdata),
        .i_raddr (n_idx),
        .o_rdata (w_rd_data)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_step     = (r_state != ST_IDLE) && (!r_out_valid || i_m_tready);

    always_comb begin
        case (r_state)
            ST_SEG: begin
                w_addr    = 16'h0000;
                w_type    = btih_pkg::TYPE_SEGMENT;
                w_payload = (r_idx == '0) ? r_last_seg[15:8] : r_last_seg[7:0];
            end
            ST_DATA: begin
                w_addr    = r_cur[15:0];
                w_type    = btih_pkg::TYPE_DATA;
                w_payload = w_rd_data;
            end
            default: begin
                w_addr    = r_end_addr;
                w_type    = btih_pkg::TYPE_END;
                w_payload = 8'h00;
            end
        endcase
        case (r_phase)
            PH_LEN:  w_byte = r_len;
            PH_AH:   w_byte = w_addr[15:8];
            PH_AL:   w_byte = w_addr[7:0];
            PH_TYP:  w_byte = w_type;
            PH_PAY:  w_byte = w_payload;
            PH_SUM:  w_byte = 8'h00 - r_sum;
            default: w_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_len       = r_len;
        n_sum       = r_sum;
        n_fill      = r_fill;
        n_cur       = r_cur;
        n_last_seg  = r_last_seg;
        n_end_addr  = r_end_addr;
        n_end_pend  = r_end_pend;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        w_fill_flush = r_fill;

        if (i_cfg_we) begin
            if (i_cfg_index[0] == btih_pkg::CFG_LOAD_ADDR) begin
                n_cur = i_cfg_data;
            end else begin
                n_end_addr = i_cfg_data[15:0];
            end
        end

        if (w_accept) begin
            n_phase = PH_LEN;
            n_idx   = '0;
            if (i_s_tuser[0] == btih_pkg::CMD_DATA) begin
                n_fill       = r_fill + FILL_W'(1);
                w_fill_flush = n_fill;
                n_end_pend   = 1'b0;
            end else begin
                n_end_pend = 1'b1;
            end
            if ((i_s_tuser[0] == btih_pkg::CMD_DATA &&
                 r_fill == FILL_W'(ROW_BYTES - 1)) ||
                (i_s_tuser[0] == btih_pkg::CMD_END && r_fill != '0)) begin
                if (r_cur[31:16] != r_last_seg) begin
                    n_state    = ST_SEG;
                    n_last_seg = r_cur[31:16];
                    n_len      = btih_pkg::SEG_LEN;
                end else begin
                    n_state = ST_DATA;
                    n_len   = 8'(w_fill_flush);
                end
            end else if (i_s_tuser[0] == btih_pkg::CMD_END) begin
                n_state = ST_END;
                n_len   = 8'h00;
            end
        end else if (w_step) begin
            n_out_valid = 1'b1;
            n_out_data  = {2'b00, btih_pkg::hex_char(w_byte[3:0]),
                           btih_pkg::hex_char(w_byte[7:4]), w_byte};
            n_out_user  = {r_phase == PH_SUM, r_phase == PH_LEN};
            n_out_last  = (r_phase == PH_SUM) &&
                          (r_state == ST_END || (r_state == ST_DATA && !r_end_pend));
            n_sum       = (r_phase == PH_LEN) ? w_byte : r_sum + w_byte;
            case (r_phase)
                PH_LEN: n_phase = PH_AH;
                PH_AH:  n_phase = PH_AL;
                PH_AL:  n_phase = PH_TYP;
                PH_TYP: n_phase = (r_len == 8'h00) ? PH_SUM : PH_PAY;
                PH_PAY: begin
                    if (8'(r_idx) == r_len - 8'h01) begin
                        n_phase = PH_SUM;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_LEN;
                    n_idx   = '0;
                    case (r_state)
                        ST_SEG: begin
                            n_state = ST_DATA;
                            n_len   = 8'(r_fill);
                        end
                        ST_DATA: begin
                            n_cur  = r_cur + 32'(r_fill);
                            n_fill = '0;
                            if (r_end_pend) begin
                                n_state = ST_END;
                                n_len   = 8'h00;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                        default: begin
                            n_state    = ST_IDLE;
                            n_end_pend = 1'b0;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_LEN;
            r_idx       <= '0;
            r_fill      <= '0;
            r_cur       <= 32'h0;
            r_last_seg  <= 16'h0;
            r_end_addr  <= 16'h0;
            r_end_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_fill      <= n_fill;
            r_cur       <= n_cur;
            r_last_seg  <= n_last_seg;
            r_end_addr  <= n_end_addr;
            r_end_pend  <= n_end_pend;
            r_out_valid <= n_out_valid;
        end
        r_len      <= n_len;
        r_sum      <= n_sum;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    `BTIH_ASSERT_NOW(a_fill_below_row, r_state == ST_IDLE,
        r_fill < FILL_W'(ROW_BYTES), "row count reached row size while idle")
    `BTIH_ASSERT_NOW(a_last_on_checksum, o_m_tvalid && o_m_tlast,
        o_m_tuser[1], "last word is not a checksum byte")
    `BTIH_ASSERT_NOW(a_seg_on_change, r_state == ST_IDLE && n_state == ST_SEG,
        r_cur[31:16] != r_last_seg, "address record without segment change")
    `BTIH_ASSERT_NEXT(a_partial_row_idle,
        w_accept && i_s_tuser[0] == btih_pkg::CMD_DATA &&
        r_fill != FILL_W'(ROW_BYTES - 1),
        r_state == ST_IDLE, "partial row started a record")

endmodule

// ===== tb/tb_binary_to_intel_hex_encoder_unit.sv =====
`timescale 1ns / 1ps

module tb_binary_to_intel_hex_encoder_unit;

    localparam int ROW_LEN    = 32;
    localparam int LONG_HOLD  = 400;
    localparam int ITEM_COUNT = 320;

    typedef struct {
        logic            cmd;
        btih_pkg::t_byte data;
    } t_hex_word;

    typedef struct {
        btih_pkg::t_byte value;
        btih_pkg::t_char hi;
        btih_pkg::t_char lo;
        logic            rec_start;
        logic            rec_end;
        logic            tlast;
    } t_hex_byte;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'h00;
    logic [0:0]  i_s_tuser   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_we    = 1'b0;
    logic [0:0]  i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data  = 32'h0;

    binary_to_intel_hex_encoder_unit #(
        .ROW_BYTES(ROW_LEN)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .o_m_tlast(o_m_tlast),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    t_hex_word       words_to_send[$];
    t_hex_byte       hex_bytes_due[$];
    btih_pkg::t_byte row_bytes[$];
    logic [31:0]     row_address  = 32'h0;
    logic [15:0]     segment_seen = 16'h0;
    logic [15:0]     end_address  = 16'h0;

    t_hex_word tx_word;
    t_hex_byte seen_want;
    int        tx_gap       = 0;
    int        rx_gap       = 0;
    int        hold_count   = 0;
    int        n_mismatch   = 0;
    int        n_queued     = 0;
    logic      calm         = 1'b0;
    logic      long_hold_on = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic btih_pkg::t_char nibble_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return btih_pkg::t_char'(8'h30 + nib);
        end
        return btih_pkg::t_char'(8'h41 + (nib - 4'd10));
    endfunction

    task automatic add_hex_byte(input btih_pkg::t_byte v, input logic st, input logic en);
        t_hex_byte b;
        b.value     = v;
        b.hi        = nibble_char(v[7:4]);
        b.lo        = nibble_char(v[3:0]);
        b.rec_start = st;
        b.rec_end   = en;
        b.tlast     = 1'b0;
        hex_bytes_due.push_back(b);
    endtask

    task automatic add_record(input logic [15:0] addr, input btih_pkg::t_byte rtype,
                              input btih_pkg::t_byte payload[$]);
        btih_pkg::t_byte sum;
        btih_pkg::t_byte len;
        len = btih_pkg::t_byte'(payload.size());
        sum = len + addr[15:8] + addr[7:0] + rtype;
        add_hex_byte(len, 1'b1, 1'b0);
        add_hex_byte(addr[15:8], 1'b0, 1'b0);
        add_hex_byte(addr[7:0], 1'b0, 1'b0);
        add_hex_byte(rtype, 1'b0, 1'b0);
        foreach (payload[i]) begin
            add_hex_byte(payload[i], 1'b0, 1'b0);
            sum = sum + payload[i];
        end
        add_hex_byte(8'h00 - sum, 1'b0, 1'b1);
    endtask

    task automatic flush_row_bytes();
        btih_pkg::t_byte seg[$];
        if (row_address[31:16] != segment_seen) begin
            seg.push_back(row_address[31:24]);
            seg.push_back(row_address[23:16]);
            add_record(16'h0000, btih_pkg::TYPE_SEGMENT, seg);
            segment_seen = row_address[31:16];
        end
        add_record(row_address[15:0], btih_pkg::TYPE_DATA, row_bytes);
        row_address = row_address + 32'(row_bytes.size());
        row_bytes.delete();
    endtask

    task automatic encode_word(input t_hex_word w);
        btih_pkg::t_byte none[$];
        int              n0;
        n0 = hex_bytes_due.size();
        if (w.cmd == btih_pkg::CMD_DATA) begin
            row_bytes.push_back(w.data);
            if (row_bytes.size() == ROW_LEN) begin
                flush_row_bytes();
            end
        end else begin
            if (row_bytes.size() != 0) begin
                flush_row_bytes();
            end
            add_record(end_address, btih_pkg::TYPE_END, none);
        end
        if (hex_bytes_due.size() > n0) begin
            hex_bytes_due[hex_bytes_due.size() - 1].tlast = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_mismatch < 50) begin
            $display("mismatch %s at %0t: got %0h want %0h", what, $realtime, got, want);
        end
        n_mismatch++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                encode_word(tx_word);
            end
            if (i_s_tvalid && !o_s_tready) begin
                // hold the word
            end else if (tx_gap > 0) begin
                tx_gap     <= tx_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (words_to_send.size() != 0 && !calm
                         && $urandom_range(0, 7) == 0) begin
                tx_gap     <= $urandom_range(0, 16);
                i_s_tvalid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                tx_word     = words_to_send.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= tx_word.data;
                i_s_tuser  <= tx_word.cmd;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (long_hold_on && hold_count < LONG_HOLD) begin
            hold_count <= hold_count + 1;
            i_m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap     <= rx_gap - 1;
            i_m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_gap     <= $urandom_range(0, 16);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (hex_bytes_due.size() == 0) begin
                report_mismatch("unexpected word", 32'(o_m_tdata), 32'h0);
            end else begin
                seen_want = hex_bytes_due.pop_front();
                if (o_m_tdata[7:0] !== seen_want.value) begin
                    report_mismatch("record_byte", 32'(o_m_tdata[7:0]), 32'(seen_want.value));
                end
                if (o_m_tdata[14:8] !== seen_want.hi) begin
                    report_mismatch("hex_high_char", 32'(o_m_tdata[14:8]), 32'(seen_want.hi));
                end
                if (o_m_tdata[21:15] !== seen_want.lo) begin
                    report_mismatch("hex_low_char", 32'(o_m_tdata[21:15]), 32'(seen_want.lo));
                end
                if (o_m_tdata[23:22] !== 2'b00) begin
                    report_mismatch("tdata pad", 32'(o_m_tdata[23:22]), 32'h0);
                end
                if (o_m_tuser[0] !== seen_want.rec_start) begin
                    report_mismatch("record_start", 32'(o_m_tuser[0]),
                                    32'(seen_want.rec_start));
                end
                if (o_m_tuser[1] !== seen_want.rec_end) begin
                    report_mismatch("record_end", 32'(o_m_tuser[1]), 32'(seen_want.rec_end));
                end
                if (o_m_tlast !== seen_want.tlast) begin
                    report_mismatch("tlast", 32'(o_m_tlast), 32'(seen_want.tlast));
                end
            end
        end
    end

    task automatic queue_word(input logic cmd, input btih_pkg::t_byte data);
        t_hex_word w;
        w.cmd  = cmd;
        w.data = data;
        words_to_send.push_back(w);
        n_queued++;
    endtask

    task automatic queue_random_word();
        queue_word(($urandom_range(0, 29) == 0) ? btih_pkg::CMD_END : btih_pkg::CMD_DATA,
                   btih_pkg::t_byte'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (words_to_send.size() != 0 || i_s_tvalid || hex_bytes_due.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == btih_pkg::CFG_LOAD_ADDR) begin
            row_address = val;
        end else begin
            end_address = val[15:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic pick_settings();
        logic [31:0] addr;
        logic [15:0] fin;
        case ($urandom_range(0, 5))
            0:       addr = 32'h0000_0000;
            1:       addr = 32'hFFFF_FFFF;
            2:       addr = {16'($urandom_range(0, 65535)), 16'hFFF0 + 16'($urandom_range(0, 15))};
            3:       addr = {16'hFFFF, 16'hFFE0 + 16'($urandom_range(0, 31))};
            default: addr = $urandom;
        endcase
        case ($urandom_range(0, 2))
            0:       fin = 16'h0000;
            1:       fin = 16'hFFFF;
            default: fin = 16'($urandom_range(0, 65535));
        endcase
        cfg_write(btih_pkg::CFG_LOAD_ADDR, addr);
        cfg_write(btih_pkg::CFG_END_ADDR, {16'h0, fin});
    endtask

    initial begin
        int phase;
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // end with nothing buffered, then a partial row and two ends, from reset defaults
        queue_word(btih_pkg::CMD_END, 8'hFF);
        queue_word(btih_pkg::CMD_DATA, 8'h00);
        queue_word(btih_pkg::CMD_DATA, 8'hFF);
        queue_word(btih_pkg::CMD_DATA, 8'h5A);
        queue_word(btih_pkg::CMD_DATA, 8'hA5);
        queue_word(btih_pkg::CMD_DATA, 8'h0F);
        queue_word(btih_pkg::CMD_DATA, 8'hF0);
        queue_word(btih_pkg::CMD_END, 8'h00);
        queue_word(btih_pkg::CMD_END, 8'h3C);
        wait_drained();

        // segment change on a partial row
        cfg_write(btih_pkg::CFG_LOAD_ADDR, 32'h0001_FFFE);
        cfg_write(btih_pkg::CFG_END_ADDR, 32'h0000_FFFF);
        queue_word(btih_pkg::CMD_DATA, 8'h80);
        queue_word(btih_pkg::CMD_DATA, 8'h01);
        queue_word(btih_pkg::CMD_END, 8'h00);
        wait_drained();

        // top of the address space, then wrap to zero
        cfg_write(btih_pkg::CFG_LOAD_ADDR, 32'hFFFF_FFFF);
        queue_word(btih_pkg::CMD_DATA, 8'h7F);
        queue_word(btih_pkg::CMD_END, 8'h00);
        queue_word(btih_pkg::CMD_DATA, 8'h33);
        queue_word(btih_pkg::CMD_END, 8'h00);
        queue_word(btih_pkg::CMD_DATA, 8'hC3);
        wait_drained();

        // load address rewritten with a byte still in the row
        cfg_write(btih_pkg::CFG_LOAD_ADDR, 32'h1234_5678);
        queue_word(btih_pkg::CMD_DATA, 8'h11);
        queue_word(btih_pkg::CMD_END, 8'h00);
        wait_drained();

        phase = 0;
        while (n_queued < ITEM_COUNT) begin
            pick_settings();
            if (n_queued >= ITEM_COUNT - 50) begin
                calm = 1'b1;
            end
            if (phase == 2) begin
                long_hold_on = 1'b1;
                for (int i = 0; i < 64; i++) begin
                    queue_word(btih_pkg::CMD_DATA, btih_pkg::t_byte'($urandom_range(0, 255)));
                end
                while (hold_count < LONG_HOLD) begin
                    @(negedge i_clk);
                end
                long_hold_on = 1'b0;
            end else begin
                n = $urandom_range(30, 50);
                for (int i = 0; i < n; i++) begin
                    queue_random_word();
                end
            end
            wait_drained();
            phase++;
        end
        queue_word(btih_pkg::CMD_END, btih_pkg::t_byte'($urandom_range(0, 255)));
        wait_drained();
        repeat (20) @(negedge i_clk);

        if (n_mismatch == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== binary_to_intel_hex_encoder_unit.f =====
+incdir+src
src/btih_pkg.sv
src/btih_ram.sv
src/binary_to_intel_hex_encoder_unit.sv
tb/tb_binary_to_intel_hex_encoder_unit.sv
